>>> sv/dlr_pkg.sv
// shared types and constants of the dda line rasterizer
// no dependencies; every other file of the block uses this package
`default_nettype none

package dlr_pkg;

    localparam int COORD_BITS   = 10;
    localparam int FRAC_BITS    = 16;
    localparam int WIDTH_BITS   = 11;
    localparam int COLOR_BITS   = 8;
    localparam int OFFSET_BITS  = 22;
    localparam int BYTE_SHIFT   = 2;
    localparam int CNT_BITS     = COORD_BITS + 1;
    localparam int STEP_BITS    = FRAC_BITS + COORD_BITS + 1;
    localparam int ACC_BITS     = STEP_BITS + 1;
    localparam int DIV_BITS     = COORD_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
    localparam int PROD_BITS    = COORD_BITS + WIDTH_BITS;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(320);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef enum logic {
        OP_LOAD,
        OP_STEP
    } op_t;

    typedef enum logic [1:0] {
        ST_DISPATCH,
        ST_DIVIDE,
        ST_FINISH
    } back_state_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [COLOR_BITS-1:0] alpha;
    } color_t;

    typedef struct packed {
        logic                  mode;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
        logic [COLOR_BITS-1:0] red_in;
        logic [COLOR_BITS-1:0] green_in;
        logic [COLOR_BITS-1:0] blue_in;
        logic [COLOR_BITS-1:0] alpha_in;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  pixel_x;
        logic [COORD_BITS-1:0]  pixel_y;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [COLOR_BITS-1:0]  red_out;
        logic [COLOR_BITS-1:0]  green_out;
        logic [COLOR_BITS-1:0]  blue_out;
        logic [COLOR_BITS-1:0]  alpha_out;
        logic                   last_pixel;
    } out_item_t;

    typedef struct packed {
        op_t                   op;
        logic                  x_major;
        logic [COORD_BITS-1:0] origin_major;
        logic [COORD_BITS-1:0] origin_minor;
        logic [CNT_BITS-1:0]   step_count;
        logic [COORD_BITS-1:0] minor_mag;
        logic                  minor_neg;
        color_t                color;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

>>> sv/dlr_front.sv
// front end: accepts input items and classifies them into queue commands
// depends on dlr_pkg
`default_nettype none

module dlr_front (
    input  wire dlr_pkg::in_item_t      s_data,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire dlr_pkg::queue_status_t q_status,
    output logic                        q_push,
    output dlr_pkg::cmd_t               q_cmd
);

    logic signed [dlr_pkg::COORD_BITS:0] dx;
    logic signed [dlr_pkg::COORD_BITS:0] dy;
    logic signed [dlr_pkg::COORD_BITS:0] dmaj;
    logic signed [dlr_pkg::COORD_BITS:0] dmin;
    logic [dlr_pkg::COORD_BITS-1:0]      adx;
    logic [dlr_pkg::COORD_BITS-1:0]      ady;
    logic                                x_major;
    logic                                swap;
    logic                                dmin_pos;

    assign dx = $signed({1'b0, s_data.x_end}) - $signed({1'b0, s_data.x_start});
    assign dy = $signed({1'b0, s_data.y_end}) - $signed({1'b0, s_data.y_start});

    assign adx = dx[dlr_pkg::COORD_BITS] ? dlr_pkg::COORD_BITS'(-dx)
                                         : dx[dlr_pkg::COORD_BITS-1:0];
    assign ady = dy[dlr_pkg::COORD_BITS] ? dlr_pkg::COORD_BITS'(-dy)
                                         : dy[dlr_pkg::COORD_BITS-1:0];

    // tie goes to y-major
    assign x_major  = adx > ady;
    assign dmaj     = x_major ? dx : dy;
    assign dmin     = x_major ? dy : dx;
    assign swap     = dmaj[dlr_pkg::COORD_BITS];
    assign dmin_pos = !dmin[dlr_pkg::COORD_BITS] && (dmin != '0);

    assign s_ready = !q_status.full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_cmd.op      = (s_data.mode == dlr_pkg::MODE_STEP) ? dlr_pkg::OP_STEP
                                                           : dlr_pkg::OP_LOAD;
        q_cmd.x_major = x_major;
        // swapped lines start at the end point
        if (swap) begin
            q_cmd.origin_major = x_major ? s_data.x_end : s_data.y_end;
            q_cmd.origin_minor = x_major ? s_data.y_end : s_data.x_end;
            q_cmd.minor_neg    = dmin_pos;
        end else begin
            q_cmd.origin_major = x_major ? s_data.x_start : s_data.y_start;
            q_cmd.origin_minor = x_major ? s_data.y_start : s_data.x_start;
            q_cmd.minor_neg    = dmin[dlr_pkg::COORD_BITS];
        end
        q_cmd.step_count  = {1'b0, (x_major ? adx : ady)};
        q_cmd.minor_mag   = x_major ? ady : adx;
        q_cmd.color.red   = s_data.red_in;
        q_cmd.color.green = s_data.green_in;
        q_cmd.color.blue  = s_data.blue_in;
        q_cmd.color.alpha = s_data.alpha_in;
    end

endmodule

`default_nettype wire

>>> sv/dlr_queue.sv
// short command queue between front and back end
// depends on dlr_pkg
`default_nettype none

module dlr_queue (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         push,
    input  wire dlr_pkg::cmd_t          push_cmd,
    input  wire                         pop,
    output dlr_pkg::cmd_t               pop_cmd,
    output dlr_pkg::queue_status_t      status
);

    dlr_pkg::cmd_t                  store_reg [dlr_pkg::QUEUE_DEPTH];
    logic [dlr_pkg::QPTR_BITS-1:0]  wr_ptr_reg;
    logic [dlr_pkg::QPTR_BITS-1:0]  rd_ptr_reg;
    logic [dlr_pkg::QCNT_BITS-1:0]  count_reg;
    logic [dlr_pkg::QCNT_BITS-1:0]  count_next;
    logic                           do_push;
    logic                           do_pop;

    assign status.full  = count_reg == dlr_pkg::QCNT_BITS'(dlr_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_cmd      = store_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + dlr_pkg::QCNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - dlr_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == dlr_pkg::QPTR_BITS'(dlr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + dlr_pkg::QPTR_BITS'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == dlr_pkg::QPTR_BITS'(dlr_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + dlr_pkg::QPTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/dlr_back.sv
// back end: line setup with serial divider, pixel stepping and output register
// depends on dlr_pkg
`default_nettype none

module dlr_back (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire dlr_pkg::queue_status_t         q_status,
    input  wire dlr_pkg::cmd_t                  q_cmd,
    output logic                                q_pop,
    input  wire [dlr_pkg::WIDTH_BITS-1:0]       surface_width,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output dlr_pkg::out_item_t                  m_data
);

    dlr_pkg::back_state_t               state_reg;
    dlr_pkg::back_state_t               state_next;

    logic                               line_active_reg;
    logic                               x_major_reg;
    logic [dlr_pkg::COORD_BITS-1:0]     origin_major_reg;
    logic [dlr_pkg::COORD_BITS-1:0]     origin_minor_reg;
    logic [dlr_pkg::CNT_BITS-1:0]       step_index_reg;
    logic [dlr_pkg::CNT_BITS-1:0]       step_count_reg;
    logic signed [dlr_pkg::STEP_BITS-1:0] minor_step_reg;
    logic signed [dlr_pkg::ACC_BITS-1:0]  minor_accum_reg;
    dlr_pkg::color_t                    color_reg;
    logic                               minor_neg_reg;
    logic [dlr_pkg::COORD_BITS-1:0]     rem_reg;
    logic [dlr_pkg::COORD_BITS-1:0]     rem_next;
    logic [dlr_pkg::DIV_BITS-1:0]       quo_reg;
    logic [dlr_pkg::DIV_BITS-1:0]       quo_next;
    logic [dlr_pkg::DIV_CNT_BITS-1:0]   div_cnt_reg;
    logic                               m_valid_reg;
    dlr_pkg::out_item_t                 m_data_reg;

    logic                               out_ready;
    logic                               load_en;
    logic                               div_step;
    logic                               finish;
    logic                               emit;

    logic [dlr_pkg::CNT_BITS:0]         rem_shift;
    logic                               rem_ge;
    logic [dlr_pkg::STEP_BITS-1:0]      quo_mag;

    logic [dlr_pkg::COORD_BITS-1:0]     maj;
    logic [dlr_pkg::COORD_BITS-1:0]     mnr;
    logic [dlr_pkg::COORD_BITS-1:0]     px;
    logic [dlr_pkg::COORD_BITS-1:0]     py;
    logic                               last;
    logic [dlr_pkg::PROD_BITS-1:0]      row_prod;
    logic [dlr_pkg::OFFSET_BITS-1:0]    lin_index;
    dlr_pkg::out_item_t                 pix;

    assign out_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // restoring divider, one quotient bit per cycle
    assign rem_shift = {1'b0, rem_reg, quo_reg[dlr_pkg::DIV_BITS-1]};
    assign rem_ge    = rem_shift >= {1'b0, step_count_reg};
    assign rem_next  = rem_ge ? dlr_pkg::COORD_BITS'(rem_shift - {1'b0, step_count_reg})
                              : rem_shift[dlr_pkg::COORD_BITS-1:0];
    assign quo_next  = {quo_reg[dlr_pkg::DIV_BITS-2:0], rem_ge};
    assign quo_mag   = dlr_pkg::STEP_BITS'(quo_reg[dlr_pkg::FRAC_BITS:0]);

    // current pixel
    assign maj  = origin_major_reg + step_index_reg[dlr_pkg::COORD_BITS-1:0];
    assign mnr  = origin_minor_reg
                + minor_accum_reg[dlr_pkg::FRAC_BITS +: dlr_pkg::COORD_BITS];
    assign px   = x_major_reg ? maj : mnr;
    assign py   = x_major_reg ? mnr : maj;
    assign last = ({1'b0, step_index_reg} + (dlr_pkg::CNT_BITS + 1)'(1))
                  >= {1'b0, step_count_reg};
    assign row_prod  = dlr_pkg::PROD_BITS'(py) * dlr_pkg::PROD_BITS'(surface_width);
    assign lin_index = dlr_pkg::OFFSET_BITS'(row_prod) + dlr_pkg::OFFSET_BITS'(px);

    always_comb begin
        pix.pixel_x     = px;
        pix.pixel_y     = py;
        pix.byte_offset = lin_index << dlr_pkg::BYTE_SHIFT;
        pix.red_out     = color_reg.red;
        pix.green_out   = color_reg.green;
        pix.blue_out    = color_reg.blue;
        pix.alpha_out   = color_reg.alpha;
        pix.last_pixel  = last;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dlr_pkg::ST_DISPATCH: begin
                if (!q_status.empty && q_cmd.op == dlr_pkg::OP_LOAD
                    && q_cmd.step_count != '0) begin
                    state_next = dlr_pkg::ST_DIVIDE;
                end
            end
            dlr_pkg::ST_DIVIDE: begin
                if (div_cnt_reg == '0) begin
                    state_next = dlr_pkg::ST_FINISH;
                end
            end
            dlr_pkg::ST_FINISH: begin
                state_next = dlr_pkg::ST_DISPATCH;
            end
            default: begin
                state_next = dlr_pkg::ST_DISPATCH;
            end
        endcase
    end

    // control outputs
    always_comb begin
        q_pop    = 1'b0;
        load_en  = 1'b0;
        div_step = 1'b0;
        finish   = 1'b0;
        emit     = 1'b0;
        unique case (state_reg)
            dlr_pkg::ST_DISPATCH: begin
                if (!q_status.empty) begin
                    priority if (q_cmd.op == dlr_pkg::OP_LOAD) begin
                        q_pop   = 1'b1;
                        load_en = 1'b1;
                    end else if (!line_active_reg) begin
                        q_pop = 1'b1;
                    end else if (out_ready) begin
                        q_pop = 1'b1;
                        emit  = 1'b1;
                    end
                end
            end
            dlr_pkg::ST_DIVIDE: begin
                div_step = 1'b1;
            end
            dlr_pkg::ST_FINISH: begin
                finish = 1'b1;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= dlr_pkg::ST_DISPATCH;
            line_active_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_en) begin
                line_active_reg <= 1'b0;
            end else if (finish) begin
                line_active_reg <= 1'b1;
            end else if (emit && last) begin
                line_active_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            x_major_reg      <= q_cmd.x_major;
            origin_major_reg <= q_cmd.origin_major;
            origin_minor_reg <= q_cmd.origin_minor;
            step_count_reg   <= q_cmd.step_count;
            minor_neg_reg    <= q_cmd.minor_neg;
            color_reg        <= q_cmd.color;
            step_index_reg   <= '0;
            minor_accum_reg  <= '0;
            rem_reg          <= '0;
            quo_reg          <= {q_cmd.minor_mag, {dlr_pkg::FRAC_BITS{1'b0}}};
            div_cnt_reg      <= dlr_pkg::DIV_CNT_BITS'(dlr_pkg::DIV_BITS - 1);
        end
        if (div_step) begin
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            div_cnt_reg <= div_cnt_reg - dlr_pkg::DIV_CNT_BITS'(1);
        end
        if (finish) begin
            minor_step_reg <= minor_neg_reg ? -$signed(quo_mag) : $signed(quo_mag);
        end
        if (emit) begin
            step_index_reg  <= step_index_reg + dlr_pkg::CNT_BITS'(1);
            minor_accum_reg <= minor_accum_reg
                             + {minor_step_reg[dlr_pkg::STEP_BITS-1], minor_step_reg};
            m_data_reg      <= pix;
        end
    end

endmodule

`default_nettype wire

>>> sv/dda_line_rasterizer_core.sv
// top level of the dda line rasterizer: width register, front end, queue, back end
// depends on dlr_pkg, dlr_front, dlr_queue, dlr_back
//
// usage:
//   s_valid/s_ready/s_data carry items; mode 0 loads a line (endpoints, rgba color),
//   mode 1 asks for the next pixel of the current line. a load gives no result;
//   a step gives one pixel while a line is active and nothing otherwise.
//   m_valid/m_ready/m_data carry pixels: coordinates, byte offset (x + y*width)*4
//   modulo 2^22, color and a last flag on the final pixel (larger-major end excluded).
//   cfg_valid/cfg_ready/cfg_data write surface_width; write it only while idle.
// queueing and throughput:
//   an item enters a two-entry command queue in the cycle of its transfer.
//   a step is written to the output register at the edge that pops it, so m_valid
//   rises once the item has passed the queue storage and the back end is free.
//   steps sustain one pixel per cycle while m_ready stays high and no load is busy.
//   a load of a non-zero line occupies the back end through setup, a divide step
//   for each quotient bit of the 26-bit serial divider, and finish; a zero-length
//   load is popped without leaving dispatch. the front end keeps accepting until
//   the queue is full.
// reset and stall:
//   reset empties the queue, drops any line and sets surface_width to 320.
//   when m_ready is low the pixel holds in the output register, the back end pops
//   no further steps of the active line, and s_ready falls once the queue fills.

`default_nettype none

module dda_line_rasterizer_core (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire dlr_pkg::in_item_t          s_data,
    output logic                            m_valid,
    input  wire                             m_ready,
    output dlr_pkg::out_item_t              m_data,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [dlr_pkg::WIDTH_BITS-1:0]   cfg_data
);

    logic [dlr_pkg::WIDTH_BITS-1:0] width_reg;
    dlr_pkg::queue_status_t         q_status;
    dlr_pkg::cmd_t                  push_cmd;
    dlr_pkg::cmd_t                  pop_cmd;
    logic                           q_push;
    logic                           q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= dlr_pkg::WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            width_reg <= cfg_data;
        end
    end

    dlr_front u_front (
        .s_data   (s_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    dlr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    dlr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .surface_width (width_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule

`default_nettype wire
